// ===== src/radix_digit_converter_defines.svh =====
// Assertion helpers for the radix digit converter.
`ifndef RADIX_DIGIT_CONVERTER_DEFINES_SVH
`define RADIX_DIGIT_CONVERTER_DEFINES_SVH

`ifndef SYNTHESIS
// Plain property check on the rising clock, off while reset is high.
`define RDC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("rdc check failed");
// Same-cycle implication check.
`define RDC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rdc implication failed");
// Next-cycle implication check.
`define RDC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rdc next-cycle check failed");
`else
`define RDC_ASSERT(label, clk, rst, prop)
`define RDC_ASSERT_IMP(label, clk, rst, ante, cons)
`define RDC_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== src/rdc_pkg.sv =====
package rdc_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int MAX_RADIX   = 256;
  localparam int STACK_DEPTH = 32;

  localparam int RADIX_W  = 9;
  localparam int DIGIT_W  = 9;
  localparam int STATUS_W = 2;
  localparam int REM_W    = RADIX_W - 1;          // remainder < radix <= 256
  localparam int STEP_W   = $clog2(VALUE_WIDTH);
  localparam int IDX_W    = $clog2(STACK_DEPTH);
  localparam int PTR_W    = $clog2(STACK_DEPTH + 1);

  localparam int S_TDATA_W = ((VALUE_WIDTH + RADIX_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((DIGIT_W + 7) / 8) * 8;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DIGIT     = 2'd0,
    STATUS_ZERO      = 2'd1,
    STATUS_BAD_RADIX = 2'd2
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic load;          // capture input word, clear stack and divider
    logic div_step;      // one restoring-division step
    logic push;          // push remainder, restart divider
    logic pop;           // move top digit into output register
    logic emit_special;  // single zero / bad-radix result
  } rdc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic bad_radix;
    logic value_zero;
    logic step_last;
    logic mag_zero;
    logic stack_one;
    logic stack_empty;
    logic out_free;
  } rdc_sts_t;

endpackage

// ===== src/rdc_datapath.sv =====
module rdc_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  rdc_pkg::rdc_cmd_t              cmd,
  output rdc_pkg::rdc_sts_t              sts,
  input  logic [rdc_pkg::VALUE_WIDTH-1:0] in_value,
  input  logic [rdc_pkg::RADIX_W-1:0]    in_radix,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [rdc_pkg::DIGIT_W-1:0]    out_digit,
  output rdc_pkg::status_t               out_status,
  output logic                           out_last
);
  import rdc_pkg::*;

  logic [VALUE_WIDTH-1:0] mag;
  logic [REM_W-1:0]       rem;
  logic [RADIX_W-1:0]     radix_r;
  logic                   neg;
  logic [STEP_W-1:0]      step;
  logic [PTR_W-1:0]       ptr;
  logic [REM_W-1:0]       stack_mem [STACK_DEPTH];

  logic [RADIX_W-1:0]     rem_sh;
  logic                   ge;
  logic [RADIX_W-1:0]     rem_diff;
  logic [PTR_W-1:0]       top_ptr;
  logic [DIGIT_W-1:0]     top_digit;

  // restoring division, one quotient bit per step; quotient shifts into mag
  assign rem_sh   = {rem, mag[VALUE_WIDTH-1]};
  assign ge       = (rem_sh >= radix_r);
  assign rem_diff = rem_sh - radix_r;

  assign top_ptr   = ptr - PTR_W'(1);
  assign top_digit = {{(DIGIT_W - REM_W){1'b0}}, stack_mem[top_ptr[IDX_W-1:0]]};

  assign sts.bad_radix   = (32'(radix_r) < 32'd2) || (32'(radix_r) > 32'(MAX_RADIX));
  assign sts.value_zero  = (mag == '0);
  assign sts.mag_zero    = (mag == '0);
  assign sts.step_last   = (step == STEP_W'(VALUE_WIDTH - 1));
  assign sts.stack_one   = (ptr == PTR_W'(1));
  assign sts.stack_empty = (ptr == '0);
  assign sts.out_free    = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg     <= in_value[VALUE_WIDTH-1];
      mag     <= in_value[VALUE_WIDTH-1] ? (~in_value + VALUE_WIDTH'(1)) : in_value;
      radix_r <= in_radix;
      rem     <= '0;
      step    <= '0;
      ptr     <= '0;
    end else if (cmd.div_step) begin
      mag  <= {mag[VALUE_WIDTH-2:0], ge};
      rem  <= ge ? rem_diff[REM_W-1:0] : rem_sh[REM_W-1:0];
      step <= step + STEP_W'(1);
    end else if (cmd.push) begin
      rem  <= '0;
      step <= '0;
      // digits beyond the stack depth are dropped
      if (ptr < PTR_W'(STACK_DEPTH)) begin
        ptr <= ptr + PTR_W'(1);
      end
    end else if (cmd.pop) begin
      ptr <= top_ptr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && (ptr < PTR_W'(STACK_DEPTH))) begin
      stack_mem[ptr[IDX_W-1:0]] <= rem;
    end
  end

  // output register, read port of the stack lands here
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.pop || cmd.emit_special) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      out_digit  <= neg ? (-top_digit) : top_digit;
      out_status <= STATUS_DIGIT;
      out_last   <= sts.stack_one;
    end else if (cmd.emit_special) begin
      out_digit  <= '0;
      out_status <= sts.bad_radix ? STATUS_BAD_RADIX : STATUS_ZERO;
      out_last   <= 1'b1;
    end
  end

endmodule

// ===== src/rdc_ctrl.sv =====
module rdc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rdc_pkg::rdc_sts_t sts,
  output rdc_pkg::rdc_cmd_t cmd
);
  import rdc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SPECIAL,
    ST_DIV,
    ST_PUSH,
    ST_POP
  } state_t;

  state_t state;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE:    cmd.load         = in_valid;
      ST_SPECIAL: cmd.emit_special = sts.out_free;
      ST_DIV:     cmd.div_step     = 1'b1;
      ST_PUSH:    cmd.push         = 1'b1;
      ST_POP:     cmd.pop          = sts.out_free;
      default:    cmd              = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) state <= ST_CHECK;
        end
        ST_CHECK: begin
          // bad radix wins over a zero value
          if (sts.bad_radix || sts.value_zero) state <= ST_SPECIAL;
          else state <= ST_DIV;
        end
        ST_SPECIAL: begin
          if (sts.out_free) state <= ST_IDLE;
        end
        ST_DIV: begin
          if (sts.step_last) state <= ST_PUSH;
        end
        ST_PUSH: begin
          // mag now holds the quotient
          if (sts.mag_zero) state <= ST_POP;
          else state <= ST_DIV;
        end
        ST_POP: begin
          if (sts.out_free && sts.stack_one) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== src/radix_digit_converter.sv =====
// Radix digit converter: takes a signed 32-bit value and a radix on the slave
// stream and returns the digits of the value in that radix on the master
// stream, most significant digit first, one word per digit, tlast on the
// final one. Digits of a negative value are negated (truncating-division
// convention), so they run from -255 to 255. A zero value returns a single
// word with status ZERO; a radix below 2 or above 256 returns a single word
// with status BAD_RADIX (this wins over a zero value); both carry digit 0 and
// tlast. One conversion is in flight at a time: s_tready is high only when the
// block is idle, but it does not wait for the last result to be taken, the
// output register holds it. Per item the block accepts the word and checks
// it, then for each digit runs 32 steps of a bit-serial restoring divider
// plus one stack push, then reads the stack out one digit at a time; the
// reads and special results wait while the output is stalled. The divider
// produces one quotient bit per clock. The digit stack holds 32 entries.
`include "radix_digit_converter_defines.svh"

module radix_digit_converter (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // s_tdata: value [31:0], radix [40:32], zero fill above
  input  logic [rdc_pkg::S_TDATA_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // m_tdata: digit [8:0], zero fill above
  output logic [rdc_pkg::M_TDATA_W-1:0]  m_tdata,
  // m_tuser: status [1:0] (0 digit, 1 zero value, 2 bad radix)
  output logic [rdc_pkg::STATUS_W-1:0]   m_tuser,
  output logic                           m_tlast
);
  import rdc_pkg::*;

  rdc_cmd_t           cmd;
  rdc_sts_t           sts;
  logic [DIGIT_W-1:0] digit;
  status_t            status;

  rdc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rdc_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_value   (s_tdata[VALUE_WIDTH-1:0]),
    .in_radix   (s_tdata[VALUE_WIDTH+RADIX_W-1:VALUE_WIDTH]),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_digit  (digit),
    .out_status (status),
    .out_last   (m_tlast)
  );

  assign m_tdata = {{(M_TDATA_W - DIGIT_W){1'b0}}, digit};
  assign m_tuser = status;

  // never overwrite a result that is still waiting
  `RDC_ASSERT_IMP(a_emit_slot, clk, rst, cmd.pop || cmd.emit_special, sts.out_free)
  // a pop always finds a digit on the stack
  `RDC_ASSERT_IMP(a_pop_nonempty, clk, rst, cmd.pop, !sts.stack_empty)
  // special results are single words with digit zero
  `RDC_ASSERT_IMP(a_special_word, clk, rst, m_tvalid && (m_tuser != STATUS_DIGIT),
                  (m_tdata == '0) && m_tlast)
  // an accepted word starts a conversion, no second accept right after
  `RDC_ASSERT_NXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready)

endmodule
